FILE: hdl/tcw_pkg.sv
// -----------------------------------------------------------------------------
// tcw_pkg
// Shared widths, command codes and control types of the text console writer.
// -----------------------------------------------------------------------------
package tcw_pkg;

	localparam int CMD_W    = 1;
	localparam int CHAR_W   = 8;
	localparam int COLOR_W  = 8;
	localparam int INDEX_W  = 11;
	localparam int CELL_W   = 16;
	localparam int LINE_O_W = 5;
	localparam int COL_O_W  = 7;
	localparam int ACTIVE_W = 5;

	localparam logic [CMD_W-1:0]    CMD_PUT  = 1'b0;
	localparam logic [CMD_W-1:0]    CMD_READ = 1'b1;
	localparam logic [CHAR_W-1:0]   NEWLINE_CODE = 8'd10;
	localparam logic [CHAR_W-1:0]   NUL_CODE     = 8'd0;
	localparam logic [ACTIVE_W-1:0] ACTIVE_LINES_RESET = 5'd25;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} tcw_ram_ctl_t;

endpackage

FILE: hdl/tcw_if.sv
// -----------------------------------------------------------------------------
// tcw_if
// Valid/ready channels of the text console writer: command, result, setup.
// -----------------------------------------------------------------------------
interface tcw_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [tcw_pkg::CMD_W-1:0]     cmd;
	logic [tcw_pkg::CHAR_W-1:0]    char_code;
	logic [tcw_pkg::COLOR_W-1:0]   color;
	logic [tcw_pkg::INDEX_W-1:0]   cell_index;

	modport source (output valid, cmd, char_code, color, cell_index, input ready);
	modport sink (input valid, cmd, char_code, color, cell_index, output ready);
endinterface

interface tcw_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [tcw_pkg::CELL_W-1:0]    read_cell;
	logic [tcw_pkg::LINE_O_W-1:0]  cursor_line;
	logic [tcw_pkg::COL_O_W-1:0]   cursor_column;
	logic                          scrolled;

	modport source (output valid, read_cell, cursor_line, cursor_column, scrolled,
		input ready);
	modport sink (input valid, read_cell, cursor_line, cursor_column, scrolled,
		output ready);
endinterface

interface tcw_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [tcw_pkg::ACTIVE_W-1:0]  active_lines;

	modport source (output valid, active_lines, input ready);
	modport sink (input valid, active_lines, output ready);
endinterface

FILE: hdl/text_console_writer_unit.sv
// -----------------------------------------------------------------------------
// text_console_writer_unit
// Text-mode console engine over a LINES x COLUMNS store of color/char cells.
// -----------------------------------------------------------------------------
//  channel   | role   | payload
//  ----------+--------+-----------------------------------------------------
//  request   | sink   | cmd, char_code, color, cell_index
//  response  | source | read_cell, cursor_line, cursor_column, scrolled
//  setup     | sink   | active_lines (always ready)
//
//  A read or plain put passes through decode, the read or put step and the
//  result register; an out-of-range read or a zero byte skips the middle step.
//  One command is taken at a time. A put that scrolls first sweeps n * COLUMNS
//  cells and drains, n being active_lines held to 1..LINES: the sweep moves one
//  cell per cycle through the single write port of the cell store.
//  After reset a clearing pass zeroes all LINES * COLUMNS cells (2000 at the
//  defaults); no command is taken until it ends.
//  The next command is taken while a result still waits on response.ready.
// -----------------------------------------------------------------------------
module text_console_writer_unit #(
	parameter int COLUMNS = 80,
	parameter int LINES   = 25
) (
	input  logic     clk,
	input  logic     arst_n,
	tcw_cmd_if.sink  request,
	tcw_rsp_if.source response,
	tcw_cfg_if.sink  setup
);
	import tcw_pkg::*;

	localparam int CELLS  = LINES * COLUMNS;
	localparam int ADDR_W = $clog2(CELLS);

	logic [ACTIVE_W-1:0] active_q;
	tcw_ram_ctl_t        ram_ctl;
	logic [ADDR_W-1:0]   wr_addr;
	logic [CELL_W-1:0]   wr_data;
	logic [ADDR_W-1:0]   rd_addr;
	logic [CELL_W-1:0]   rd_data;

	assign setup.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_LINES_RESET;
		end else if (setup.valid) begin
			active_q <= setup.active_lines;
		end
	end

	tcw_ctrl #(
		.COLUMNS (COLUMNS),
		.LINES   (LINES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.request      (request),
		.response     (response),
		.active_lines (active_q),
		.ram_ctl      (ram_ctl),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data)
	);

	tcw_cell_ram #(
		.DEPTH (CELLS)
	) u_cell_ram (
		.clk     (clk),
		.ctl     (ram_ctl),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule

FILE: hdl/tcw_cell_ram.sv
// -----------------------------------------------------------------------------
// tcw_cell_ram
// Screen cell store: one write port, one read port, registered read data.
// -----------------------------------------------------------------------------
module tcw_cell_ram #(
	parameter int DEPTH = 2000
) (
	input  logic                               clk,
	input  tcw_pkg::tcw_ram_ctl_t              ctl,
	input  logic [$clog2(DEPTH)-1:0]           wr_addr,
	input  logic [tcw_pkg::CELL_W-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0]           rd_addr,
	output logic [tcw_pkg::CELL_W-1:0]         rd_data
);
	import tcw_pkg::*;

	logic [CELL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: hdl/tcw_ctrl.sv
// -----------------------------------------------------------------------------
// tcw_ctrl
// Command sequencer: clearing pass, scroll sweep, put and read, result register.
// -----------------------------------------------------------------------------
module tcw_ctrl #(
	parameter int COLUMNS = 80,
	parameter int LINES   = 25
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	tcw_cmd_if.sink                                   request,
	tcw_rsp_if.source                                 response,
	input  logic [tcw_pkg::ACTIVE_W-1:0]              active_lines,
	output tcw_pkg::tcw_ram_ctl_t                     ram_ctl,
	output logic [$clog2(LINES*COLUMNS)-1:0]          wr_addr,
	output logic [tcw_pkg::CELL_W-1:0]                wr_data,
	output logic [$clog2(LINES*COLUMNS)-1:0]          rd_addr,
	input  logic [tcw_pkg::CELL_W-1:0]                rd_data
);
	import tcw_pkg::*;

	localparam int CELLS  = LINES * COLUMNS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int LINE_W = $clog2(LINES + 1);
	localparam int COL_W  = $clog2(COLUMNS);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_DECODE = 3'd2;
	localparam logic [2:0] ST_SCROLL = 3'd3;
	localparam logic [2:0] ST_DRAIN  = 3'd4;
	localparam logic [2:0] ST_PUT    = 3'd5;
	localparam logic [2:0] ST_READ   = 3'd6;
	localparam logic [2:0] ST_FIN    = 3'd7;

	logic [2:0]          state_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [CHAR_W-1:0]   char_q;
	logic [COLOR_W-1:0]  color_q;
	logic [INDEX_W-1:0]  idx_q;
	logic [LINE_W-1:0]   line_q;
	logic [COL_W-1:0]    col_q;
	logic [ADDR_W-1:0]   ptr_q;
	logic [ADDR_W-1:0]   keep_end_q;
	logic [ADDR_W-1:0]   last_q;
	logic                scrolled_q;
	logic [CELL_W-1:0]   cell_q;

	logic                wr_vld_s1;
	logic [ADDR_W-1:0]   wr_addr_s1;
	logic                wr_zero_s1;

	logic                out_valid_q;
	logic [CELL_W-1:0]   out_cell_q;
	logic [LINE_W-1:0]   out_line_q;
	logic [COL_W-1:0]    out_col_q;
	logic                out_scrolled_q;

	logic [LINE_W-1:0]   n_eff;
	logic                in_range;
	logic                out_load;
	logic [ADDR_W-1:0]   put_addr;

	// Clamp the active line count into 1..LINES
	always_comb begin
		if (active_lines == '0) begin
			n_eff = LINE_W'(1);
		end else if (32'(active_lines) > 32'(LINES)) begin
			n_eff = LINE_W'(LINES);
		end else begin
			n_eff = LINE_W'(active_lines);
		end
	end

	assign in_range = 32'(idx_q) < 32'(CELLS);
	assign put_addr = ADDR_W'(32'(line_q) * COLUMNS) + ADDR_W'(col_q);
	assign out_load = (state_q == ST_FIN) && (!out_valid_q || response.ready);

	always_comb begin
		ram_ctl = '0;
		wr_addr = ptr_q;
		wr_data = '0;
		rd_addr = ADDR_W'(idx_q);
		case (state_q)
			ST_CLEAR: begin
				ram_ctl.wr_en = 1'b1;
			end
			ST_DECODE: begin
				ram_ctl.rd_en = (cmd_q == CMD_READ) && in_range;
			end
			ST_SCROLL: begin
				// Fetch the cell one line below; the last line gets no fetch
				ram_ctl.rd_en = ptr_q < keep_end_q;
				rd_addr       = ptr_q + ADDR_W'(COLUMNS);
			end
			ST_PUT: begin
				ram_ctl.wr_en = char_q != NEWLINE_CODE;
				wr_addr       = put_addr;
				wr_data       = {color_q, char_q};
			end
			default: begin
			end
		endcase
		// Write back the cell fetched in the previous cycle one line up, or zero on the last line
		if (wr_vld_s1) begin
			ram_ctl.wr_en = 1'b1;
			wr_addr       = wr_addr_s1;
			wr_data       = wr_zero_s1 ? '0 : rd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			ptr_q       <= '0;
			line_q      <= '0;
			col_q       <= '0;
			wr_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			wr_vld_s1 <= state_q == ST_SCROLL;
			case (state_q)
				ST_CLEAR: begin
					if (ptr_q == ADDR_W'(CELLS - 1)) begin
						ptr_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (request.valid) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					if (cmd_q == CMD_READ) begin
						state_q <= in_range ? ST_READ : ST_FIN;
					end else if (char_q == NUL_CODE) begin
						state_q <= ST_FIN;
					end else if (line_q >= n_eff) begin
						ptr_q   <= '0;
						line_q  <= n_eff - 1'b1;
						state_q <= ST_SCROLL;
					end else begin
						state_q <= ST_PUT;
					end
				end
				ST_SCROLL: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == last_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_PUT;
				end
				ST_PUT: begin
					if (char_q == NEWLINE_CODE || col_q == COL_W'(COLUMNS - 1)) begin
						line_q <= line_q + 1'b1;
						col_q  <= '0;
					end else begin
						col_q <= col_q + 1'b1;
					end
					state_q <= ST_FIN;
				end
				ST_READ: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (response.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && request.valid) begin
			cmd_q   <= request.cmd;
			char_q  <= request.char_code;
			color_q <= request.color;
			idx_q   <= request.cell_index;
		end
		if (state_q == ST_DECODE) begin
			cell_q     <= '0;
			scrolled_q <= (cmd_q == CMD_PUT) && (char_q != NUL_CODE) && (line_q >= n_eff);
			keep_end_q <= ADDR_W'(32'(n_eff) * COLUMNS - COLUMNS);
			last_q     <= ADDR_W'(32'(n_eff) * COLUMNS - 1);
		end
		if (state_q == ST_READ) begin
			cell_q <= rd_data;
		end
		wr_addr_s1 <= ptr_q;
		wr_zero_s1 <= ptr_q >= keep_end_q;
		if (out_load) begin
			out_cell_q     <= cell_q;
			out_line_q     <= line_q;
			out_col_q      <= col_q;
			out_scrolled_q <= scrolled_q;
		end
	end

	assign request.ready          = state_q == ST_IDLE;
	assign response.valid         = out_valid_q;
	assign response.read_cell     = out_cell_q;
	assign response.cursor_line   = LINE_O_W'(out_line_q);
	assign response.cursor_column = COL_O_W'(out_col_q);
	assign response.scrolled      = out_scrolled_q;

endmodule

FILE: hdl/tcw_checker.sv
// -----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// -----------------------------------------------------------------------------
module tcw_checker #(
	parameter int COLUMNS = 80
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic [tcw_pkg::CELL_W-1:0]     rsp_cell,
	input logic [tcw_pkg::LINE_O_W-1:0]   rsp_line,
	input logic [tcw_pkg::COL_O_W-1:0]    rsp_col,
	input logic                           rsp_scrolled
);
	import tcw_pkg::*;

	// One command in flight: a transfer in drops ready for the next cycle
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request ready held after a transfer");

	// A fresh result is loaded only while no command is being taken
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_ready))
		else $error("result appeared without work behind it");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell) &&
		$stable(rsp_line) && $stable(rsp_col) && $stable(rsp_scrolled))
		else $error("stalled result changed");

	a_column_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> 32'(rsp_col) < 32'(COLUMNS))
		else $error("cursor column beyond line end");

endmodule

bind text_console_writer_unit tcw_checker #(
	.COLUMNS (COLUMNS)
) u_tcw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (request.valid),
	.req_ready    (request.ready),
	.rsp_valid    (response.valid),
	.rsp_ready    (response.ready),
	.rsp_cell     (response.read_cell),
	.rsp_line     (response.cursor_line),
	.rsp_col      (response.cursor_column),
	.rsp_scrolled (response.scrolled)
);
